// File: rtl/gmf_pkg.sv
// gmf_pkg: shared types, constants and helper functions of the gray median filter
// used by gmf_line_store, gmf_median9 and gray_median3x3_filter_unit; no dependencies
`default_nettype none

package gmf_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 12;
  localparam int CFG_W     = 12;
  localparam int PIX_W     = 8;

  // luma weights 0.3 / 0.59 / 0.11 in unsigned q0.8
  localparam int GRAY_COEF_R = 77;
  localparam int GRAY_COEF_G = 151;
  localparam int GRAY_COEF_B = 28;

  localparam logic [WIDTH_W-1:0]  WIDTH_MIN   = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);
  localparam logic [WIDTH_W-1:0]  WIDTH_RST   = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN  = HEIGHT_W'(3);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST  = HEIGHT_W'(480);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [3:0]       win_idx_t;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  // compare-exchange pairs of the 19-element median-of-nine network
  localparam int MED_STEPS = 19;
  localparam win_idx_t MED_LO [MED_STEPS] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
  };
  localparam win_idx_t MED_HI [MED_STEPS] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
    4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
  };

  function automatic pix_t gray_of(input pix_t r, input pix_t g, input pix_t b);
    logic [15:0] sum;
    sum = 16'(r) * 16'(GRAY_COEF_R) + 16'(g) * 16'(GRAY_COEF_G)
        + 16'(b) * 16'(GRAY_COEF_B);
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

// File: rtl/gmf_line_store.sv
// gmf_line_store: the two gray line stores (upper and middle row) with registered read
// depends on gmf_pkg; a write in the same cycle as a read of the same column is forwarded
`default_nettype none

module gmf_line_store
  import gmf_pkg::*;
(
  input  logic clk,
  input  logic rd_en,
  input  col_t rd_addr,
  input  logic wr_en,
  input  col_t wr_addr,
  input  pix_t up_wdata,
  input  pix_t mid_wdata,
  output pix_t up_rdata,
  output pix_t mid_rdata
);

  pix_t up_mem  [MAX_WIDTH];
  pix_t mid_mem [MAX_WIDTH];

  pix_t up_q;
  pix_t mid_q;
  pix_t up_fwd;
  pix_t mid_fwd;
  logic hit;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q    <= up_mem[rd_addr];
      mid_q   <= mid_mem[rd_addr];
      hit     <= wr_en && (wr_addr == rd_addr);
      up_fwd  <= up_wdata;
      mid_fwd <= mid_wdata;
    end
    if (wr_en) begin
      up_mem[wr_addr]  <= up_wdata;
      mid_mem[wr_addr] <= mid_wdata;
    end
  end

  assign up_rdata  = hit ? up_fwd  : up_q;
  assign mid_rdata = hit ? mid_fwd : mid_q;

endmodule

`default_nettype wire

// File: rtl/gmf_median9.sv
// gmf_median9: median of a 3x3 window by a fixed compare-exchange network
// depends on gmf_pkg for the pixel type and the network's pair tables
`default_nettype none

module gmf_median9
  import gmf_pkg::*;
(
  input  pix_t win [9],
  output pix_t median
);

  pix_t p [9];

  always_comb begin
    pix_t lo;
    pix_t hi;
    p = win;
    for (int k = 0; k < MED_STEPS; k++) begin
      lo = p[MED_LO[k]];
      hi = p[MED_HI[k]];
      if (lo > hi) begin
        p[MED_LO[k]] = hi;
        p[MED_HI[k]] = lo;
      end
    end
  end

  assign median = p[4];

endmodule

`default_nettype wire

// File: rtl/gray_median3x3_filter_unit.sv
// gray_median3x3_filter_unit: rgb to gray conversion followed by a 3x3 median filter
// depends on gmf_pkg, gmf_line_store and gmf_median9
`default_nettype none

// Takes one rgb pixel (or flush) per clock in raster order and gives one result per
// clock at full rate: every transaction is accepted whenever the output register is free
// or being emptied, so the input and output sides run one pixel per cycle back to back.
// Each pixel becomes gray = (77*r + 151*g + 28*b) >> 8. Interior pixels of the frame get
// the median of their 3x3 neighborhood of unfiltered gray values; pixels in the first or
// last row or column pass through unchanged and are marked with was_filtered low.
// Results trail the input by one row plus one pixel: the first eff_w+1 pixels
// after reset, after a configuration write or after a drained tail give no result.
// Pixels of the next frame push out the tail of the previous one; otherwise flush
// transactions (operation high), sent right after the last pixel of a frame, drain the
// tail one result each. A flush at any other time is dropped. A pixel that arrives after
// a partly drained tail drops the rest of the tail and starts a new frame.
// Pipeline: accept (line store read issued) -> gray, window and store update ->
// median -> output register; a stalled output register holds every stage.
// Line stores are two single-port-write, one-read memories of MAX_WIDTH
// entries; they need no clearing after reset. image_width is taken into 3..MAX_WIDTH and
// image_height below 3 reads as 3; a write to either register restarts the frame and
// must only be done while the block is idle.

module gray_median3x3_filter_unit
  import gmf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  input  logic                cfg_write,
  input  logic [0:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [0:0]          operation,
  input  logic [PIX_W-1:0]    red,
  input  logic [PIX_W-1:0]    green,
  input  logic [PIX_W-1:0]    blue,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [PIX_W-1:0]    gray_out,
  output logic                was_filtered,
  output logic                frame_end
);

  // configuration
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [WIDTH_W-1:0]  full;

  // frame position of the next input pixel and of the next result
  col_t                col;
  logic [HEIGHT_W-1:0] row;
  col_t                ecol;
  logic [HEIGHT_W-1:0] erow;
  logic [WIDTH_W-1:0]  backlog;

  col_t                col_next;
  logic [HEIGHT_W-1:0] row_next;
  col_t                ecol_next;
  logic [HEIGHT_W-1:0] erow_next;
  logic [WIDTH_W-1:0]  backlog_next;

  // decode of the transaction at the input
  logic is_flush;
  logic at_start;
  logic take;
  logic emit;
  logic inner;
  logic fend;
  logic use_w5;
  col_t rd_addr;
  logic accept;
  logic adv;

  // stage b: gray, window and line store update
  logic b_valid;
  logic b_flush;
  logic b_emit;
  logic b_inner;
  logic b_fend;
  logic b_use_w5;
  col_t b_addr;
  pix_t b_red;
  pix_t b_green;
  pix_t b_blue;
  pix_t b_gray;
  logic b_wr;

  pix_t up_rdata;
  pix_t mid_rdata;

  pix_t win [9];

  // stage m: median
  logic m_valid;
  logic m_inner;
  logic m_fend;
  pix_t m_bval;
  pix_t med;

  // effective frame size
  always_comb begin
    if (image_width < WIDTH_MIN) begin
      eff_w = WIDTH_MIN;
    end else if (image_width > WIDTH_MAX) begin
      eff_w = WIDTH_MAX;
    end else begin
      eff_w = image_width;
    end
    eff_h = (image_height < HEIGHT_MIN) ? HEIGHT_MIN : image_height;
    full  = eff_w + WIDTH_W'(1);
  end

  // whole pipeline moves when the output register is free or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  // control decisions for the transaction at the input
  always_comb begin
    col_t                ec;
    logic [HEIGHT_W-1:0] er;
    logic [WIDTH_W-1:0]  bl;
    logic                may_filter;

    col_next     = col;
    row_next     = row;
    ecol_next    = ecol;
    erow_next    = erow;
    backlog_next = backlog;
    take         = 1'b0;
    emit         = 1'b0;
    inner        = 1'b0;
    fend         = 1'b0;
    use_w5       = 1'b0;
    may_filter   = 1'b0;
    ec           = ecol;
    er           = erow;
    bl           = backlog;

    at_start = (col == '0) && (row == '0);
    is_flush = (op_t'(operation) == OP_FLUSH);
    rd_addr  = is_flush ? ecol : col;

    if (is_flush) begin
      // tail drain only right after a complete frame
      if ((backlog != '0) && at_start) begin
        take         = 1'b1;
        emit         = 1'b1;
        use_w5       = (backlog == full);
        backlog_next = backlog - WIDTH_W'(1);
      end
    end else begin
      take = 1'b1;
      // pixel after a partly drained tail: drop the rest and start afresh
      if (at_start && (bl != '0) && (bl != full)) begin
        bl = '0;
        ec = '0;
        er = '0;
      end
      if ({1'b0, col} == eff_w - WIDTH_W'(1)) begin
        col_next = '0;
        row_next = (row == eff_h - HEIGHT_W'(1)) ? '0 : row + HEIGHT_W'(1);
      end else begin
        col_next = col + COL_W'(1);
      end
      if (bl == full) begin
        emit         = 1'b1;
        may_filter   = 1'b1;
        backlog_next = bl;
      end else begin
        backlog_next = bl + WIDTH_W'(1);
      end
      ecol_next = ec;
      erow_next = er;
    end

    if (emit) begin
      inner = may_filter && (er != '0) && (er <= eff_h - HEIGHT_W'(2))
           && (ec != '0) && ({1'b0, ec} <= eff_w - WIDTH_W'(2));
      fend  = ({1'b0, ec} == eff_w - WIDTH_W'(1)) && (er == eff_h - HEIGHT_W'(1));
      if (fend) begin
        ecol_next = '0;
        erow_next = '0;
      end else if ({1'b0, ec} == eff_w - WIDTH_W'(1)) begin
        ecol_next = '0;
        erow_next = er + HEIGHT_W'(1);
      end else begin
        ecol_next = ec + COL_W'(1);
        erow_next = er;
      end
    end
  end

  // configuration registers and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      col          <= '0;
      row          <= '0;
      ecol         <= '0;
      erow         <= '0;
      backlog      <= '0;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default:          image_width  <= image_width;
      endcase
      col     <= '0;
      row     <= '0;
      ecol    <= '0;
      erow    <= '0;
      backlog <= '0;
    end else if (accept) begin
      col     <= col_next;
      row     <= row_next;
      ecol    <= ecol_next;
      erow    <= erow_next;
      backlog <= backlog_next;
    end
  end

  // stage b registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= accept && take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_flush  <= is_flush;
      b_emit   <= emit;
      b_inner  <= inner;
      b_fend   <= fend;
      b_use_w5 <= use_w5;
      b_addr   <= rd_addr;
      b_red    <= red;
      b_green  <= green;
      b_blue   <= blue;
    end
  end

  assign b_gray = gray_of(b_red, b_green, b_blue);
  assign b_wr   = adv && b_valid && !b_flush;

  // upper row takes the old middle entry, middle row takes the new gray
  gmf_line_store u_line_store (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (rd_addr),
    .wr_en     (b_wr),
    .wr_addr   (b_addr),
    .up_wdata  (mid_rdata),
    .mid_wdata (b_gray),
    .up_rdata  (up_rdata),
    .mid_rdata (mid_rdata)
  );

  // 3x3 window of unfiltered gray values, columns shift left, new column at the right
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (b_wr) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= up_rdata;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= mid_rdata;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= b_gray;
    end
  end

  // stage m registers: border value chosen here, median taken from the updated window
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= b_valid && b_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_inner <= b_inner;
      m_fend  <= b_fend;
      if (!b_flush || b_use_w5) begin
        m_bval <= win[5];
      end else begin
        m_bval <= mid_rdata;
      end
    end
  end

  gmf_median9 u_median9 (
    .win    (win),
    .median (med)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gray_out     <= m_inner ? med : m_bval;
      was_filtered <= m_inner;
      frame_end    <= m_fend;
    end
  end

endmodule

`default_nettype wire
